/* sv/mtss_pkg.sv */
// Shared types and constants for the multi-tone sinusoid synthesizer.
`timescale 1ns / 1ps

package mtss_pkg;

  localparam int TONE_REGS        = 4;
  localparam int MAX_TONES_DEF    = 4;
  localparam int TABLE_BITS_DEF   = 10;

  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;
  localparam int COUNT_W          = 3;
  localparam int SAMPLE_W         = 18;
  localparam int SAMPLE_MAX       = 131071;
  localparam int SAMPLE_MIN       = -131072;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TONE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_FIRST = 3'd1;

  localparam logic [COUNT_W-1:0] TONE_COUNT_RST = 3'd1;

  typedef struct packed {
    logic [15:0]        offset;
    logic [31:0]        inc;
    logic signed [15:0] amp;
  } tone_t;

  // control that travels down the cell chain alongside the partial sum
  typedef struct packed {
    logic valid;
    logic restart;
  } link_t;

endpackage

/* sv/mtss_if.sv */
// Valid/ready channel interfaces for tick requests and sample results.
`timescale 1ns / 1ps

interface mtss_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mtss_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* sv/multi_tone_sinusoid_synth.sv */
// Top level of the multi-tone sinusoid synthesizer: config registers and cell chain.
//
//  channel     dir  payload         accepted when
//  tick_if     in   restart (1b)    valid && ready
//  sample_if   out  sample (18b s)  valid && ready
//  cfg port    in   index 3b, 64b   cfg_we_i
//
// One tick request enters per cycle unless the result register stalls. Each tone
// cell is three stages deep, ahead of the result register. Reset clears the phase
// accumulators, sets tone_count to 1 and the tone registers to 0. A stalled result
// register freezes the whole chain and drops tick ready in the same cycle.
`timescale 1ns / 1ps

module multi_tone_sinusoid_synth #(
  parameter int MAX_TONES  = mtss_pkg::MAX_TONES_DEF,
  parameter int TABLE_BITS = mtss_pkg::TABLE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  mtss_in_if.sink                            tick_if,
  mtss_out_if.source                         sample_if,
  input  logic                               cfg_we_i,
  input  logic [mtss_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mtss_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mtss_pkg::*;

  localparam int N_CELLS = (MAX_TONES < TONE_REGS) ? MAX_TONES : TONE_REGS;
  localparam int SUM_W   = 34 + $clog2(N_CELLS);

  logic [COUNT_W-1:0] tone_count_q;
  logic [COUNT_W-1:0] active;
  tone_t              tone_q [N_CELLS];
  link_t              link [N_CELLS+1];
  logic signed [SUM_W-1:0] sum [N_CELLS+1];
  logic               adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_count_q <= TONE_COUNT_RST;
    end else if (cfg_we_i && cfg_index_i == REG_TONE_COUNT) begin
      tone_count_q <= cfg_data_i[COUNT_W-1:0];
    end
  end

  assign active = (tone_count_q > COUNT_W'(N_CELLS)) ? COUNT_W'(N_CELLS) : tone_count_q;

  assign link[0]       = '{valid: tick_if.valid, restart: tick_if.restart};
  assign sum[0]        = '0;
  assign tick_if.ready = adv;

  for (genvar j = 0; j < N_CELLS; j++) begin : g_cell
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tone_q[j] <= '0;
      end else if (cfg_we_i && cfg_index_i == CFG_IDX_W'(REG_TONE_FIRST + j)) begin
        tone_q[j] <= tone_t'(cfg_data_i);
      end
    end

    mtss_cell #(
      .TABLE_BITS (TABLE_BITS),
      .SUM_W      (SUM_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .enable_i (active > COUNT_W'(j)),
      .tone_i   (tone_q[j]),
      .link_i   (link[j]),
      .sum_i    (sum[j]),
      .link_o   (link[j+1]),
      .sum_o    (sum[j+1])
    );
  end

  mtss_out #(
    .SUM_W (SUM_W)
  ) u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .link_i   (link[N_CELLS]),
    .sum_i    (sum[N_CELLS]),
    .ready_i  (sample_if.ready),
    .adv_o    (adv),
    .valid_o  (sample_if.valid),
    .sample_o (sample_if.sample)
  );

  a_count_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == REG_TONE_COUNT |=> tone_count_q == $past(cfg_data_i[2:0]))
    else $error("tone_count write lost");

endmodule

/* sv/mtss_cell.sv */
// One tone cell: phase accumulator, quarter-wave cosine lookup and multiply-add.
`timescale 1ns / 1ps

module mtss_cell #(
  parameter int TABLE_BITS = 10,
  parameter int SUM_W      = 34
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  logic                    enable_i,
  input  mtss_pkg::tone_t         tone_i,
  input  mtss_pkg::link_t         link_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output mtss_pkg::link_t         link_o,
  output logic signed [SUM_W-1:0] sum_o
);
  import mtss_pkg::*;

  localparam int     TBL_N       = 1 << TABLE_BITS;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  // (2i-1)*(2i) for Taylor terms i = 1..10
  localparam longint TAYLOR_DIV [10] = '{
    64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90,
    64'sd132, 64'sd182, 64'sd240, 64'sd306, 64'sd380
  };

  typedef logic [14:0] cos_tbl_t [TBL_N];

  // cos(pi/2 * k / N) in Q0.15, Taylor series in Q30, rounded half up
  function automatic cos_tbl_t build_tbl();
    cos_tbl_t tbl;
    longint   x;
    longint   x2;
    longint   term;
    longint   acc;
    for (int k = 0; k < TBL_N; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) >>> TABLE_BITS;
      x2   = (x * x) >>> 30;
      term = ONE_Q30;
      acc  = term;
      for (int i = 1; i <= 10; i++) begin
        term = -(term * x2) / ONE_Q30;
        term = term / TAYLOR_DIV[i-1];
        acc  = acc + term;
      end
      if (acc < 0) acc = 0;
      acc = (acc + 64'sd16384) >>> 15;
      if (acc > 64'sd32767) acc = 64'sd32767;
      tbl[k] = 15'(acc);
    end
    return tbl;
  endfunction

  localparam cos_tbl_t COS_TBL = build_tbl();

  logic [31:0]           acc_q;
  logic [31:0]           base;
  logic [31:0]           phase;
  logic [TABLE_BITS-1:0] k_idx;
  logic [TABLE_BITS-1:0] addr_d;
  logic                  zero_d;
  logic                  neg_d;

  link_t                 ctl1_q, ctl2_q, ctl3_q;
  logic signed [SUM_W-1:0] sum1_q, sum2_q, sum3_q, sum3_d;
  logic [TABLE_BITS-1:0] addr1_q;
  logic                  zero1_q, neg1_q;
  logic [14:0]           cos2_q;
  logic signed [16:0]    amp_x;
  logic signed [16:0]    amp2_d, amp2_q;
  logic signed [32:0]    prod;

  assign base  = link_i.restart ? '0 : acc_q;
  assign phase = base + {tone_i.offset, 16'h0000};
  assign k_idx = phase[29 -: TABLE_BITS];

  // odd quadrants read the table mirrored; index N there is the zero entry
  always_comb begin
    addr_d = phase[30] ? (~k_idx + 1'b1) : k_idx;
    zero_d = phase[30] && (k_idx == '0);
    neg_d  = phase[31] ^ phase[30];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (adv_i && link_i.valid) begin
      acc_q <= base + tone_i.inc;
    end
  end

  assign amp_x = {tone_i.amp[15], tone_i.amp};

  always_comb begin
    if (zero1_q || !enable_i) begin
      amp2_d = '0;
    end else if (neg1_q) begin
      amp2_d = -amp_x;
    end else begin
      amp2_d = amp_x;
    end
  end

  assign prod   = amp2_q * $signed({1'b0, cos2_q});
  assign sum3_d = sum2_q + SUM_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (adv_i) begin
      ctl1_q <= link_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum1_q  <= sum_i;
      addr1_q <= addr_d;
      zero1_q <= zero_d;
      neg1_q  <= neg_d;
      sum2_q  <= sum1_q;
      cos2_q  <= COS_TBL[addr1_q];
      amp2_q  <= amp2_d;
      sum3_q  <= sum3_d;
    end
  end

  assign link_o = ctl3_q;
  assign sum_o  = sum3_q;

  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv_i && link_i.valid) |=> $stable(acc_q))
    else $error("phase accumulator moved without an item");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && link_i.valid && link_i.restart |=> acc_q == $past(tone_i.inc))
    else $error("restart did not clear the accumulator");

endmodule

/* sv/mtss_out.sv */
// Output stage: truncation toward zero, saturation and the result register.
`timescale 1ns / 1ps

module mtss_out #(
  parameter int SUM_W = 34
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mtss_pkg::link_t         link_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic                    ready_i,
  output logic                    adv_o,
  output logic                    valid_o,
  output logic signed [17:0]      sample_o
);
  import mtss_pkg::*;

  localparam int Q_W = SUM_W - 15;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(SAMPLE_MAX);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(SAMPLE_MIN);

  logic                    valid_q;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic signed [SUM_W-1:0] mag;
  logic signed [SUM_W-1:0] shifted;
  logic signed [Q_W-1:0]   q;

  assign mag     = sum_i[SUM_W-1] ? -sum_i : sum_i;
  assign shifted = mag >>> 15;

  always_comb begin
    q = sum_i[SUM_W-1] ? -Q_W'(shifted) : Q_W'(shifted);
    if (q > Q_MAX) begin
      sample_d = SAMPLE_W'(Q_MAX);
    end else if (q < Q_MIN) begin
      sample_d = SAMPLE_W'(Q_MIN);
    end else begin
      sample_d = SAMPLE_W'(q);
    end
  end

  assign adv_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= link_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      sample_q <= sample_d;
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;

  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_o && link_i.valid && !sum_i[SUM_W-1] |=> !sample_q[SAMPLE_W-1])
    else $error("non-negative sum gave a negative sample");

endmodule
